[rtl/core/lprd_pkg.sv]
// shared types, codes and layout tables for the record deframer
package lprd_pkg;

    // kind of a result beat
    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    // error codes carried with an error beat
    typedef enum logic [1:0] {
        ERR_ZERO_LENGTH  = 2'd0,
        ERR_TRUNC_HEADER = 2'd1,
        ERR_TRUNC_PAYLD  = 2'd2,
        ERR_RESERVED     = 2'd3
    } err_t;

    // header fields that a layout can hold
    typedef enum logic [1:0] {
        FLD_NONE = 2'd0,
        FLD_LEN  = 2'd1,
        FLD_IP   = 2'd2,
        FLD_TIME = 2'd3
    } fld_t;

    // record_format codes
    localparam logic [2:0] FMT_LEN_ONLY  = 3'd0;
    localparam logic [2:0] FMT_IP_LEN    = 3'd1;
    localparam logic [2:0] FMT_LEN_TIME  = 3'd2;
    localparam logic [2:0] FMT_LEN_IP    = 3'd3;
    localparam logic [2:0] FMT_LEN_T_IP  = 3'd4;

    // parse position that means payload bytes follow
    localparam logic [1:0] PHASE_PAYLOAD = 2'd3;

    localparam int START_BITS = 40;

    // one result beat
    typedef struct packed {
        kind_t                   result_kind;
        logic [7:0]              payload_byte;
        logic                    last_of_record;
        logic [15:0]             record_length;
        logic [31:0]             source_address;
        logic [15:0]             source_port;
        logic [31:0]             stamp_seconds;
        logic [31:0]             stamp_nanoseconds;
        err_t                    error_code;
        logic [START_BITS-1:0]   record_start_offset;
        logic [31:0]             records_seen;
    } res_t;

    // header field found at a position of the layout
    function automatic fld_t field_at(input logic [2:0] fmt, input logic [1:0] pos);
        fld_t f;
        f = FLD_NONE;
        case (fmt)
            FMT_IP_LEN:
            begin
                if (pos == 2'd0) f = FLD_IP;
                else if (pos == 2'd1) f = FLD_LEN;
            end
            FMT_LEN_TIME:
            begin
                if (pos == 2'd0) f = FLD_LEN;
                else if (pos == 2'd1) f = FLD_TIME;
            end
            FMT_LEN_IP:
            begin
                if (pos == 2'd0) f = FLD_LEN;
                else if (pos == 2'd1) f = FLD_IP;
            end
            FMT_LEN_T_IP:
            begin
                if (pos == 2'd0) f = FLD_LEN;
                else if (pos == 2'd1) f = FLD_TIME;
                else if (pos == 2'd2) f = FLD_IP;
            end
            default:
            begin
                if (pos == 2'd0) f = FLD_LEN;
            end
        endcase
        return f;
    endfunction

    // bytes in a header field
    function automatic logic [3:0] field_size(input fld_t f);
        logic [3:0] n;
        case (f)
            FLD_LEN:  n = 4'd2;
            FLD_IP:   n = 4'd6;
            default:  n = 4'd8;
        endcase
        return n;
    endfunction

endpackage

[rtl/core/lprd_if.sv]
// stream channel interfaces for the record deframer

interface lprd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_stream;

    modport source (output valid, output data_byte, output end_of_stream, input ready);
    modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface lprd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [7:0]  payload_byte;
    logic        last_of_record;
    logic [15:0] record_length;
    logic [31:0] source_address;
    logic [15:0] source_port;
    logic [31:0] stamp_seconds;
    logic [31:0] stamp_nanoseconds;
    logic [1:0]  error_code;
    logic [39:0] record_start_offset;
    logic [31:0] records_seen;

    modport source (
        output valid, output result_kind, output payload_byte, output last_of_record,
        output record_length, output source_address, output source_port,
        output stamp_seconds, output stamp_nanoseconds, output error_code,
        output record_start_offset, output records_seen, input ready
    );
    modport sink (
        input valid, input result_kind, input payload_byte, input last_of_record,
        input record_length, input source_address, input source_port,
        input stamp_seconds, input stamp_nanoseconds, input error_code,
        input record_start_offset, input records_seen, output ready
    );
endinterface

[rtl/core/lprd_parser.sv]
// per-byte record parser: parse state and the result of one beat
module lprd_parser #(
    parameter int OFFSET_BITS = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             end_of_stream,
    input  logic [2:0]       record_format,
    output logic             res_valid,
    output lprd_pkg::res_t   res
);

    logic [1:0]             phase_reg, phase_next;
    logic [2:0]             idx_reg, idx_next;
    logic [15:0]            length_reg, length_next;
    logic [15:0]            remaining_reg, remaining_next;
    logic [31:0]            address_reg, address_next;
    logic [15:0]            port_reg, port_next;
    logic [31:0]            seconds_reg, seconds_next;
    logic [31:0]            nanos_reg, nanos_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [31:0]            total_reg, total_next;
    logic                   err_hold_reg, err_hold_next;

    logic                   starting;
    logic [OFFSET_BITS-1:0] offset_inc;
    logic [15:0]            rem_dec;
    lprd_pkg::fld_t         fld;
    logic [1:0]             phase_eff;
    logic [2:0]             idx_eff;
    logic [63:0]            start_wide;
    logic [63:0]            offset_wide;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            idx_reg       <= '0;
            length_reg    <= '0;
            remaining_reg <= '0;
            address_reg   <= '0;
            port_reg      <= '0;
            seconds_reg   <= '0;
            nanos_reg     <= '0;
            offset_reg    <= '0;
            start_reg     <= '0;
            total_reg     <= '0;
            err_hold_reg  <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            idx_reg       <= idx_next;
            length_reg    <= length_next;
            remaining_reg <= remaining_next;
            address_reg   <= address_next;
            port_reg      <= port_next;
            seconds_reg   <= seconds_next;
            nanos_reg     <= nanos_next;
            offset_reg    <= offset_next;
            start_reg     <= start_next;
            total_reg     <= total_next;
            err_hold_reg  <= err_hold_next;
        end
    end

    assign starting    = (phase_reg == 2'd0) && (idx_reg == 3'd0);
    assign offset_inc  = (offset_reg != '1) ? offset_reg + OFFSET_BITS'(1) : offset_reg;
    assign rem_dec     = remaining_reg - 16'd1;
    assign start_wide  = 64'(start_reg);
    assign offset_wide = 64'(offset_reg);

    always_comb
    begin
        phase_next     = phase_reg;
        idx_next       = idx_reg;
        length_next    = length_reg;
        remaining_next = remaining_reg;
        address_next   = address_reg;
        port_next      = port_reg;
        seconds_next   = seconds_reg;
        nanos_next     = nanos_reg;
        offset_next    = offset_reg;
        start_next     = start_reg;
        total_next     = total_reg;
        err_hold_next  = err_hold_reg;
        fld            = lprd_pkg::field_at(record_format, phase_reg);
        phase_eff      = phase_reg;
        idx_eff        = idx_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (accept)
        begin
            if (end_of_stream)
            begin
                res_valid         = 1'b1;
                res.records_seen  = total_reg;
                if (err_hold_reg || starting)
                begin
                    res.result_kind         = lprd_pkg::KIND_DONE;
                    res.record_start_offset = offset_wide[lprd_pkg::START_BITS-1:0];
                end
                else
                begin
                    res.result_kind         = lprd_pkg::KIND_ERROR;
                    res.error_code          = (phase_reg == lprd_pkg::PHASE_PAYLOAD) ?
                                              lprd_pkg::ERR_TRUNC_PAYLD :
                                              lprd_pkg::ERR_TRUNC_HEADER;
                    res.record_length       = length_reg;
                    res.source_address      = address_reg;
                    res.source_port         = port_reg;
                    res.stamp_seconds       = seconds_reg;
                    res.stamp_nanoseconds   = nanos_reg;
                    res.record_start_offset = start_wide[lprd_pkg::START_BITS-1:0];
                end
                // new stream
                phase_next     = '0;
                idx_next       = '0;
                length_next    = '0;
                remaining_next = '0;
                address_next   = '0;
                port_next      = '0;
                seconds_next   = '0;
                nanos_next     = '0;
                offset_next    = '0;
                start_next     = '0;
                total_next     = '0;
                err_hold_next  = 1'b0;
            end
            else if (err_hold_reg)
            begin
                offset_next = offset_inc;
            end
            else
            begin
                offset_next = offset_inc;
                if (starting)
                begin
                    start_next   = offset_reg;
                    length_next  = '0;
                    address_next = '0;
                    port_next    = '0;
                    seconds_next = '0;
                    nanos_next   = '0;
                end

                if (phase_reg == lprd_pkg::PHASE_PAYLOAD)
                begin
                    remaining_next     = rem_dec;
                    res_valid          = 1'b1;
                    res.result_kind    = lprd_pkg::KIND_PAYLOAD;
                    res.payload_byte   = data_byte;
                    res.last_of_record = (rem_dec == 16'd0);
                    if (rem_dec == 16'd0)
                    begin
                        if (total_reg != '1)
                            total_next = total_reg + 32'd1;
                        phase_next = '0;
                        idx_next   = '0;
                    end
                end
                else
                begin
                    // position past the layout after a format change: restart it
                    if (fld == lprd_pkg::FLD_NONE)
                    begin
                        phase_eff = 2'd0;
                        idx_eff   = 3'd0;
                        fld       = lprd_pkg::field_at(record_format, 2'd0);
                    end
                    phase_next = phase_eff;

                    case (fld)
                        lprd_pkg::FLD_LEN:
                            length_next = {length_next[7:0], data_byte};
                        lprd_pkg::FLD_IP:
                        begin
                            if (idx_eff < 3'd4)
                                address_next = {address_next[23:0], data_byte};
                            else
                                port_next = {port_next[7:0], data_byte};
                        end
                        default:
                        begin
                            if (idx_eff < 3'd4)
                                seconds_next = {seconds_next[23:0], data_byte};
                            else
                                nanos_next = {nanos_next[23:0], data_byte};
                        end
                    endcase

                    if ({1'b0, idx_eff} + 4'd1 < lprd_pkg::field_size(fld))
                    begin
                        idx_next = idx_eff + 3'd1;
                    end
                    else
                    begin
                        idx_next = '0;
                        if (length_next == 16'd0 &&
                            (fld == lprd_pkg::FLD_LEN ||
                             lprd_pkg::field_at(record_format, phase_eff + 2'd1) ==
                             lprd_pkg::FLD_NONE))
                        begin
                            res_valid      = 1'b1;
                            res.result_kind = lprd_pkg::KIND_ERROR;
                            res.error_code  = lprd_pkg::ERR_ZERO_LENGTH;
                            err_hold_next  = 1'b1;
                            phase_next     = '0;
                        end
                        else if (lprd_pkg::field_at(record_format, phase_eff + 2'd1) ==
                                 lprd_pkg::FLD_NONE)
                        begin
                            phase_next      = lprd_pkg::PHASE_PAYLOAD;
                            remaining_next  = length_next;
                            res_valid       = 1'b1;
                            res.result_kind = lprd_pkg::KIND_HEADER;
                        end
                        else
                        begin
                            phase_next = phase_eff + 2'd1;
                        end
                    end
                end

                res.record_length       = length_next;
                res.source_address      = address_next;
                res.source_port         = port_next;
                res.stamp_seconds       = seconds_next;
                res.stamp_nanoseconds   = nanos_next;
                // a record that starts on this byte begins at the current offset
                res.record_start_offset = starting ?
                                          offset_wide[lprd_pkg::START_BITS-1:0] :
                                          start_wide[lprd_pkg::START_BITS-1:0];
                res.records_seen        = total_reg;
            end
        end
    end

    // after an error the parser sits at the layout start
    a_hold_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        err_hold_reg |-> (phase_reg == 2'd0 && idx_reg == 3'd0))
        else $error("error hold away from record start");

    // payload phase always has bytes left
    a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == lprd_pkg::PHASE_PAYLOAD) |-> (remaining_reg != 16'd0))
        else $error("payload phase with nothing remaining");

    // end of stream restarts offset and count
    a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_stream) |=> (offset_reg == '0 && total_reg == '0 && !err_hold_reg))
        else $error("stream state not cleared after end of stream");

    // every end of stream gives a result
    a_eos_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_stream) |-> res_valid)
        else $error("end of stream without a result");

endmodule

[rtl/core/lprd_out_reg.sv]
// result register between the parser and the output channel
module lprd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  lprd_pkg::res_t   push_data,
    output logic             space,
    lprd_out_if.source       out_ch
);

    logic             valid_reg, valid_next;
    lprd_pkg::res_t   data_reg;

    assign space = !valid_reg || out_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
            valid_next = 1'b1;
        else if (out_ch.ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            data_reg <= push_data;
    end

    assign out_ch.valid               = valid_reg;
    assign out_ch.result_kind         = data_reg.result_kind;
    assign out_ch.payload_byte        = data_reg.payload_byte;
    assign out_ch.last_of_record      = data_reg.last_of_record;
    assign out_ch.record_length       = data_reg.record_length;
    assign out_ch.source_address      = data_reg.source_address;
    assign out_ch.source_port         = data_reg.source_port;
    assign out_ch.stamp_seconds       = data_reg.stamp_seconds;
    assign out_ch.stamp_nanoseconds   = data_reg.stamp_nanoseconds;
    assign out_ch.error_code          = data_reg.error_code;
    assign out_ch.record_start_offset = data_reg.record_start_offset;
    assign out_ch.records_seen        = data_reg.records_seen;

    // a new result never lands on one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!valid_reg || out_ch.ready))
        else $error("result overwritten before it was taken");

    // a push always shows up as a valid beat
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> valid_reg)
        else $error("pushed result not presented");

endmodule

[rtl/core/length_prefixed_record_deframer.sv]
// top level of the length-prefixed record deframer
//
// takes a byte stream of captured packet records, one beat per byte, and
// splits it into records; record_format picks the header layout (0 length
// only, 1 ip/port then length, 2 length then timestamp, 3 length then
// ip/port, 4 length, timestamp, ip/port; codes 5 to 7 act as 0), all fields
// big-endian; a header beat comes out when the last header byte arrives,
// then one beat per payload byte with last_of_record on the final one; a
// zero length, or end of stream inside a header or payload, gives an error
// beat, and after an error bytes are dropped until end of stream, which
// always gives one beat (done or error) and starts a fresh stream; the input
// takes one beat every clock while the output side keeps up, since each
// byte is parsed combinationally from the parse state straight into a
// one-deep result register; the result beat is presented in the cycle after
// its input beat is accepted; write record_format only while the block is idle
module length_prefixed_record_deframer #(
    parameter int OFFSET_BITS = 40
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,
    lprd_in_if.sink     in_ch,
    lprd_out_if.source  out_ch
);

    // header layout register
    logic [2:0]       format_reg;

    // handshake between input channel and parser
    logic             accept;
    logic             space;

    // parser result for this beat
    logic             res_valid;
    lprd_pkg::res_t   res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            format_reg <= lprd_pkg::FMT_LEN_ONLY;
        else if (cfg_wr_en)
            format_reg <= cfg_wr_data;
    end

    // take a byte whenever the result register is free or draining
    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    lprd_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (in_ch.data_byte),
        .end_of_stream (in_ch.end_of_stream),
        .record_format (format_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    lprd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .space     (space),
        .out_ch    (out_ch)
    );

    // results only come from accepted beats
    a_result_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> accept)
        else $error("result without an accepted beat");

endmodule

[tb/lprd_tb_pkg.sv]
`timescale 1ns / 1ps
// record layout helpers and the result scoreboard for the deframer testbench
package lprd_tb_pkg;
    import lprd_pkg::*;

    localparam int OFFSET_W = 40;

    // header field at a position of the stream layout, unknown codes act as length only
    function automatic fld_t layout_field(input logic [2:0] fmt, input int pos);
        fld_t order [3];
        case (fmt)
            FMT_IP_LEN:   order = '{FLD_IP, FLD_LEN, FLD_NONE};
            FMT_LEN_TIME: order = '{FLD_LEN, FLD_TIME, FLD_NONE};
            FMT_LEN_IP:   order = '{FLD_LEN, FLD_IP, FLD_NONE};
            FMT_LEN_T_IP: order = '{FLD_LEN, FLD_TIME, FLD_IP};
            default:      order = '{FLD_LEN, FLD_NONE, FLD_NONE};
        endcase
        if (pos < 0 || pos > 2)
            return FLD_NONE;
        return order[pos];
    endfunction

    function automatic int field_bytes(input fld_t f);
        case (f)
            FLD_LEN: return 2;
            FLD_IP:  return 6;
            default: return 8;
        endcase
    endfunction

    class deframe_scoreboard;
        logic [2:0]          format_reg;
        logic [1:0]          phase;
        logic [2:0]          field_idx;
        logic [15:0]         length_acc;
        logic [15:0]         payload_left;
        logic [31:0]         address_acc;
        logic [15:0]         port_acc;
        logic [31:0]         seconds_acc;
        logic [31:0]         nanos_acc;
        logic [OFFSET_W-1:0] byte_pos;
        logic [39:0]         start_pos;
        logic [31:0]         record_count;
        bit                  discarding;
        res_t                expected_beats[$];
        int unsigned         failures;

        function new();
            format_reg = FMT_LEN_ONLY;
            failures = 0;
            clear_stream();
        endfunction

        function void set_format(input logic [2:0] f);
            format_reg = f;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // fresh stream after end of stream, register untouched
        function void clear_stream();
            phase = '0;
            field_idx = '0;
            length_acc = '0;
            payload_left = '0;
            address_acc = '0;
            port_acc = '0;
            seconds_acc = '0;
            nanos_acc = '0;
            byte_pos = '0;
            start_pos = '0;
            record_count = '0;
            discarding = 1'b0;
        endfunction

        function res_t make_beat(input kind_t k, input logic [7:0] b, input logic last,
                                 input err_t e, input bit with_hdr);
            res_t r;
            r.result_kind = k;
            r.payload_byte = b;
            r.last_of_record = last;
            r.record_length = with_hdr ? length_acc : '0;
            r.source_address = with_hdr ? address_acc : '0;
            r.source_port = with_hdr ? port_acc : '0;
            r.stamp_seconds = with_hdr ? seconds_acc : '0;
            r.stamp_nanoseconds = with_hdr ? nanos_acc : '0;
            r.error_code = e;
            r.record_start_offset = start_pos;
            r.records_seen = record_count;
            return r;
        endfunction

        // parse one accepted input beat and queue any result beat it causes
        function void note_stream_beat(input logic [7:0] b, input logic eos);
            fld_t f;
            logic [2:0] idx;
            if (eos)
            begin
                if (discarding)
                begin
                    start_pos = byte_pos[39:0];
                    expected_beats.push_back(make_beat(KIND_DONE, '0, 1'b0, ERR_ZERO_LENGTH, 0));
                end
                else if (phase == PHASE_PAYLOAD)
                    expected_beats.push_back(make_beat(KIND_ERROR, '0, 1'b0, ERR_TRUNC_PAYLD, 1));
                else if (phase != '0 || field_idx != '0)
                    expected_beats.push_back(make_beat(KIND_ERROR, '0, 1'b0, ERR_TRUNC_HEADER, 1));
                else
                begin
                    start_pos = byte_pos[39:0];
                    expected_beats.push_back(make_beat(KIND_DONE, '0, 1'b0, ERR_ZERO_LENGTH, 0));
                end
                clear_stream();
                return;
            end

            if (discarding)
            begin
                if (byte_pos != '1)
                    byte_pos++;
                return;
            end

            if (phase == '0 && field_idx == '0)
            begin
                start_pos = byte_pos[39:0];
                length_acc = '0;
                address_acc = '0;
                port_acc = '0;
                seconds_acc = '0;
                nanos_acc = '0;
            end
            if (byte_pos != '1)
                byte_pos++;

            if (phase == PHASE_PAYLOAD)
            begin
                payload_left--;
                if (payload_left == '0)
                begin
                    expected_beats.push_back(make_beat(KIND_PAYLOAD, b, 1'b1, ERR_ZERO_LENGTH, 1));
                    if (record_count != '1)
                        record_count++;
                    phase = '0;
                    field_idx = '0;
                end
                else
                    expected_beats.push_back(make_beat(KIND_PAYLOAD, b, 1'b0, ERR_ZERO_LENGTH, 1));
                return;
            end

            // position left over from another layout restarts the header
            f = layout_field(format_reg, int'(phase));
            if (f == FLD_NONE)
            begin
                phase = '0;
                field_idx = '0;
                f = layout_field(format_reg, 0);
            end
            idx = field_idx;

            case (f)
                FLD_LEN: length_acc = {length_acc[7:0], b};
                FLD_IP:
                begin
                    if (idx < 3'd4)
                        address_acc = {address_acc[23:0], b};
                    else
                        port_acc = {port_acc[7:0], b};
                end
                default:
                begin
                    if (idx < 3'd4)
                        seconds_acc = {seconds_acc[23:0], b};
                    else
                        nanos_acc = {nanos_acc[23:0], b};
                end
            endcase

            if (int'(idx) + 1 < field_bytes(f))
            begin
                field_idx = 3'(int'(idx) + 1);
                return;
            end

            field_idx = '0;
            if (f == FLD_LEN && length_acc == '0)
            begin
                expected_beats.push_back(make_beat(KIND_ERROR, '0, 1'b0, ERR_ZERO_LENGTH, 1));
                discarding = 1'b1;
                phase = '0;
                return;
            end

            phase++;
            if (layout_field(format_reg, int'(phase)) == FLD_NONE)
            begin
                phase = PHASE_PAYLOAD;
                payload_left = length_acc;
                // length never seen after a layout change counts as zero length
                if (payload_left == '0)
                begin
                    expected_beats.push_back(make_beat(KIND_ERROR, '0, 1'b0, ERR_ZERO_LENGTH, 1));
                    discarding = 1'b1;
                    phase = '0;
                    return;
                end
                expected_beats.push_back(make_beat(KIND_HEADER, '0, 1'b0, ERR_ZERO_LENGTH, 1));
            end
        endfunction

        function void compare_field(input string name, input logic [63:0] want,
                                    input logic [63:0] got);
            if (got !== want)
            begin
                if (failures < 60)
                    $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result_beat(input res_t got);
            res_t want;
            if (expected_beats.size() == 0)
            begin
                if (failures < 60)
                    $error("result beat with nothing expected, kind %0d", got.result_kind);
                failures++;
                return;
            end
            want = expected_beats.pop_front();
            compare_field("result_kind", 64'(want.result_kind), 64'(got.result_kind));
            compare_field("payload_byte", 64'(want.payload_byte), 64'(got.payload_byte));
            compare_field("last_of_record", 64'(want.last_of_record), 64'(got.last_of_record));
            compare_field("record_length", 64'(want.record_length), 64'(got.record_length));
            compare_field("source_address", 64'(want.source_address), 64'(got.source_address));
            compare_field("source_port", 64'(want.source_port), 64'(got.source_port));
            compare_field("stamp_seconds", 64'(want.stamp_seconds), 64'(got.stamp_seconds));
            compare_field("stamp_nanoseconds", 64'(want.stamp_nanoseconds),
                          64'(got.stamp_nanoseconds));
            compare_field("error_code", 64'(want.error_code), 64'(got.error_code));
            compare_field("record_start_offset", 64'(want.record_start_offset),
                          64'(got.record_start_offset));
            compare_field("records_seen", 64'(want.records_seen), 64'(got.records_seen));
        endfunction
    endclass

endpackage

[tb/tb.sv]
`timescale 1ns / 1ps
// testbench top for the length-prefixed record deframer
module tb;
    import lprd_pkg::*;
    import lprd_tb_pkg::*;

    // one input beat: a stream byte or the end marker
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
    } stream_beat_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_wr_en;
    logic [2:0] cfg_wr_data;

    lprd_in_if  in_ch ();
    lprd_out_if out_ch ();

    length_prefixed_record_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );

    deframe_scoreboard sb;
    stream_beat_t      stream_q[$];     // beats waiting to be offered
    bit                hold_off_req = 1'b0;
    int                random_items = 0;
    int                phase_no;
    int                settle;

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop for a hung run
    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------

    task automatic push_byte(input logic [7:0] b);
        stream_beat_t beat;
        beat.data = b;
        beat.eos = 1'b0;
        stream_q.push_back(beat);
    endtask

    // end marker carries a random byte that the block must ignore
    task automatic push_eos();
        stream_beat_t beat;
        beat.data = 8'($urandom);
        beat.eos = 1'b1;
        stream_q.push_back(beat);
    endtask

    // header bytes in the order of the active layout, all big-endian
    task automatic push_header(input logic [15:0] len, input logic [31:0] addr,
                               input logic [15:0] port, input logic [31:0] sec,
                               input logic [31:0] nsec);
        fld_t f;
        for (int pos = 0; pos < 3; pos++)
        begin
            f = layout_field(sb.format_reg, pos);
            case (f)
                FLD_LEN:
                begin
                    push_byte(len[15:8]);
                    push_byte(len[7:0]);
                end
                FLD_IP:
                begin
                    for (int k = 3; k >= 0; k--)
                        push_byte(addr[8*k +: 8]);
                    push_byte(port[15:8]);
                    push_byte(port[7:0]);
                end
                FLD_TIME:
                begin
                    for (int k = 3; k >= 0; k--)
                        push_byte(sec[8*k +: 8]);
                    for (int k = 3; k >= 0; k--)
                        push_byte(nsec[8*k +: 8]);
                end
                default: ;
            endcase
        end
    endtask

    // whole record with random header values, now and then all zeros or all ones
    task automatic push_record(input logic [15:0] len);
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] sec;
        logic [31:0] nsec;
        addr = $urandom;
        port = 16'($urandom);
        sec = $urandom;
        nsec = $urandom;
        case ($urandom_range(0, 9))
            0:
            begin
                addr = '0;
                port = '0;
                sec = '0;
                nsec = '0;
            end
            1:
            begin
                addr = '1;
                port = '1;
                sec = '1;
                nsec = '1;
            end
            default: ;
        endcase
        push_header(len, addr, port, sec, nsec);
        repeat (len) push_byte(8'($urandom));
    endtask

    // mostly short payloads, a few longer ones
    function automatic logic [15:0] pick_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70)
            return 16'($urandom_range(1, 8));
        else if (roll < 95)
            return 16'($urandom_range(9, 48));
        return 16'($urandom_range(49, 300));
    endfunction

    // one stream: well-formed records, then a clean end or a broken one
    task automatic push_stream();
        int n_rec;
        int roll;
        int mark;
        int added;
        int keep;
        logic [15:0] big_len;
        n_rec = $urandom_range(1, 5);
        for (int i = 0; i < n_rec; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                push_record(pick_length());
            else if (roll < 86)
            begin
                // zero length, then a few bytes that must be dropped
                push_header('0, $urandom, 16'($urandom), $urandom, $urandom);
                repeat ($urandom_range(0, 3)) push_byte(8'($urandom));
                push_eos();
                return;
            end
            else if (roll < 92)
            begin
                // record cut short inside header or payload
                mark = stream_q.size();
                push_record(pick_length());
                added = stream_q.size() - mark;
                keep = $urandom_range(1, added - 1);
                repeat (added - keep) void'(stream_q.pop_back());
                push_eos();
                return;
            end
            else if (roll < 96)
            begin
                // large length cut short early in the payload
                big_len = 16'($urandom_range(49, 65535));
                push_header(big_len, $urandom, 16'($urandom), $urandom, $urandom);
                repeat ($urandom_range(0, 6)) push_byte(8'($urandom));
                push_eos();
                return;
            end
            else
            begin
                // garbage bytes
                repeat ($urandom_range(1, 5)) push_byte(8'($urandom));
                push_eos();
                return;
            end
        end
        push_eos();
    endtask

    // ---------------------------------------------------------------
    // driving
    // ---------------------------------------------------------------

    // offer the queued beats in bursts with random gaps between them
    task automatic run_stream();
        stream_beat_t item;
        int burst;
        int gap;
        while (stream_q.size() > 0)
        begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 8);
            repeat (burst)
            begin
                if (stream_q.size() > 0)
                begin
                    item = stream_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.data_byte <= item.data;
                    in_ch.end_of_stream <= item.eos;
                    @(posedge clk);
                    while (in_ch.ready !== 1'b1)
                        @(posedge clk);
                    // beat taken at this edge
                    sb.note_stream_beat(item.data, item.eos);
                end
            end
            if (gap > 0)
            begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid <= 1'b0;
    endtask

    // sender holds until every expected beat is back
    task automatic wait_idle();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_format(input logic [2:0] f);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= f;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_format(f);
    endtask

    // ---------------------------------------------------------------
    // result side: checks every accepted beat, stalls on its own pattern
    // ---------------------------------------------------------------
    initial
    begin : result_sink
        int   mode;
        int   mode_left;
        int   hold_left;
        logic take;
        res_t got;
        out_ch.ready <= 1'b0;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got.result_kind = kind_t'(out_ch.result_kind);
                got.payload_byte = out_ch.payload_byte;
                got.last_of_record = out_ch.last_of_record;
                got.record_length = out_ch.record_length;
                got.source_address = out_ch.source_address;
                got.source_port = out_ch.source_port;
                got.stamp_seconds = out_ch.stamp_seconds;
                got.stamp_nanoseconds = out_ch.stamp_nanoseconds;
                got.error_code = err_t'(out_ch.error_code);
                got.record_start_offset = out_ch.record_start_offset;
                got.records_seen = out_ch.records_seen;
                sb.check_result_beat(got);
            end
            // long hold-off so the result register fills and the input backs up
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = 400;
            end
            // stall mode: always ready, coin flip, mostly stalled, or periodic
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 256);
            end
            else
                mode_left--;
            case (mode)
                0:       take = 1'b1;
                1:       take = 1'($urandom_range(0, 1));
                2:       take = ($urandom_range(0, 3) == 0);
                default: take = ((mode_left % 3) != 0);
            endcase
            if (hold_left > 0)
            begin
                hold_left--;
                take = 1'b0;
            end
            out_ch.ready <= take;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------
    initial
    begin
        sb = new();
        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_wr_data <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data_byte <= '0;
        in_ch.end_of_stream <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset layout (length only)
        // single byte payload of all ones, clean end
        push_byte(8'h00);
        push_byte(8'h01);
        push_byte(8'hFF);
        push_eos();
        // zero length, a dropped byte, end after the error
        push_byte(8'h00);
        push_byte(8'h00);
        push_byte(8'hAA);
        push_eos();
        // end inside the header
        push_byte(8'h12);
        push_eos();
        // end inside the payload
        push_byte(8'h00);
        push_byte(8'h02);
        push_byte(8'h55);
        push_eos();
        // empty stream
        push_eos();
        run_stream();
        wait_idle();

        // layout change in the middle of a header: time field turns into ip/port
        write_format(FMT_LEN_T_IP);
        push_byte(8'h00);
        push_byte(8'h03);
        push_byte(8'($urandom));
        push_byte(8'($urandom));
        run_stream();
        wait_idle();
        write_format(FMT_LEN_IP);
        repeat (4) push_byte(8'($urandom));
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'($urandom));
        push_eos();
        run_stream();
        wait_idle();

        // random phases, every format code once in turn, then random codes
        phase_no = 0;
        while (random_items < 1000)
        begin
            write_format(phase_no < 8 ? 3'(phase_no) : 3'($urandom_range(0, 7)));
            while (stream_q.size() < 80)
                push_stream();
            random_items += stream_q.size();
            if (phase_no == 2 || phase_no == 9)
                hold_off_req = 1'b1;
            run_stream();
            wait_idle();
            phase_no++;
        end

        // longest length field in the widest layout, stream cut early in the payload
        write_format(FMT_LEN_T_IP);
        push_header(16'hFFFF, '1, '1, '1, '1);
        repeat (20) push_byte(8'($urandom));
        push_eos();
        run_stream();

        // drain, then give stray beats a chance to show up
        settle = 0;
        while (sb.pending() != 0 && settle < 20000)
        begin
            @(posedge clk);
            settle++;
        end
        if (sb.pending() != 0)
        begin
            $error("%0d expected result beats never arrived", sb.pending());
            sb.failures++;
        end
        repeat (16) @(posedge clk);

        if (sb.failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/lprd_pkg.sv
rtl/core/lprd_if.sv
rtl/core/lprd_parser.sv
rtl/core/lprd_out_reg.sv
rtl/core/length_prefixed_record_deframer.sv
tb/lprd_tb_pkg.sv
tb/tb.sv
